@@ rtl/tsfvl_pkg.sv @@
// Package for the two-sector flash value log core.
// Types, codes and sizes shared by the core and the testbench; the core sizes its RAM instances from them.
package tsfvl_pkg;

  localparam int unsigned RECORDS     = 512;
  localparam int unsigned VALUE_COUNT = 32;
  localparam int unsigned REC_AW      = $clog2(RECORDS);
  localparam int unsigned VAL_AW      = $clog2(VALUE_COUNT);
  localparam int unsigned CNT_W       = 10;

  typedef enum logic [2:0] {
    OP_LOAD_SIG  = 3'd0,
    OP_LOAD_SER  = 3'd1,
    OP_LOAD_SNAP = 3'd2,
    OP_LOAD_REC  = 3'd3,
    OP_MOUNT     = 3'd4,
    OP_SAVE      = 3'd5,
    OP_READ      = 3'd6,
    OP_NONE      = 3'd7
  } opcode_e;

  typedef enum logic [2:0] {
    K_STATUS = 3'd0,
    K_ERASE  = 3'd1,
    K_HEADER = 3'd2,
    K_SNAP   = 3'd3,
    K_RECORD = 3'd4,
    K_READ   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    CFG_UNLOCK = 2'd0,
    CFG_SIG    = 2'd1,
    CFG_RPS    = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_ERASE, S_HDR, S_SRD, S_SWR, S_COPY, S_REPLAY,
    S_SVCMP, S_SEARCH, S_FOUND, S_RDOUT, S_STATUS
  } state_e;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  idn;
    logic [31:0] val;
  } log_rec_t;

endpackage

@@ rtl/two_sector_flash_value_log_core.sv @@
// Two-sector flash value log core: mirror of both flash sectors plus value store.
// Depends on tsfvl_pkg and tsfvl_ram.
// Loads are written on acceptance; a read fetches the stored value through the
// value RAM's single read port. Mount copies the snapshot, then replays up to
// records_per_sector records, one record per cycle; when no sector is valid it runs
// two 512 entry erase sweeps, a header and a snapshot instead. Save scans up to
// records_per_sector slots for an empty one; when the sector is full the scan is
// followed by an erase sweep of 512 mirror entries, a header and a fresh snapshot.
// Reset: async active low; clears control, config and value-valid bits only.
module two_sector_flash_value_log_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic        in_sector_i,
  input  logic [8:0]  in_slot_i,
  input  logic [7:0]  in_id_i,
  input  logic [7:0]  in_id_check_i,
  input  logic [31:0] in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  out_kind_o,
  output logic        out_sector_o,
  output logic [8:0]  out_slot_o,
  output logic [4:0]  out_id_o,
  output logic [31:0] out_word_o,
  output logic        status_o,
  output logic        last_o
);
  import tsfvl_pkg::*;

  // configuration
  logic              unlock_q;
  logic [31:0]       sig_word_q;
  logic [CNT_W-1:0]  rps_q;
  logic [CNT_W-1:0]  cnt;

  // header mirror (undefined until written, no reset)
  logic [31:0] hdr_sig_q [2];
  logic [31:0] hdr_ser_q [2];

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  idx_q, idx_d;       // issue index
  logic [CNT_W-1:0]  didx_q, didx_d;     // index of data returning
  logic              pend_q, pend_d;     // a read returns this cycle
  logic              sec_q, sec_d;       // sector being worked on
  logic              hsec_q, hsec_d;     // sector getting the new header
  logic              two_q, two_d;       // erase sector 1 after sector 0
  logic              act_q, act_d;       // active sector
  logic              st_q, st_d;
  logic [31:0]       serial_q, serial_d;
  logic [VAL_AW-1:0] id_q, id_d;
  logic [31:0]       word_q, word_d;

  // output register
  logic        ov_q;
  kind_e       ok_q;
  logic        osec_q;
  logic [8:0]  oslot_q;
  logic [4:0]  oid_q;
  logic [31:0] oword_q;
  logic        ost_q, olast_q;

  logic        emit;
  kind_e       e_kind;
  logic        e_sec;
  logic [8:0]  e_slot;
  logic [4:0]  e_id;
  logic [31:0] e_word;
  logic        e_st, e_last;
  logic        emit_ok;

  // stored values RAM, valid bits give reset value zero
  logic                   sv_we, sv_re;
  logic [VAL_AW-1:0]      sv_waddr, sv_raddr;
  logic [31:0]            sv_wdata, sv_rdata, sv_val;
  logic [VALUE_COUNT-1:0] sv_vld_q;
  logic                   sv_rv_q;

  // snapshot RAM, both sectors
  logic              sn_we, sn_re;
  logic [VAL_AW:0]   sn_waddr, sn_raddr;
  logic [31:0]       sn_wdata, sn_rdata;

  // record mirror RAM, both sectors
  logic              rc_we, rc_re;
  logic [REC_AW:0]   rc_waddr, rc_raddr;
  log_rec_t          rc_wdata, rc_rdata;
  logic [47:0]       rc_rraw;

  logic        acc;
  logic        rec_good, rec_empty;
  logic        v0, v1;

  tsfvl_ram #(.WIDTH(32), .DEPTH(VALUE_COUNT)) u_sv (
    .clk_i, .we_i(sv_we), .waddr_i(sv_waddr), .wdata_i(sv_wdata),
    .re_i(sv_re), .raddr_i(sv_raddr), .rdata_o(sv_rdata));

  tsfvl_ram #(.WIDTH(32), .DEPTH(2*VALUE_COUNT)) u_snap (
    .clk_i, .we_i(sn_we), .waddr_i(sn_waddr), .wdata_i(sn_wdata),
    .re_i(sn_re), .raddr_i(sn_raddr), .rdata_o(sn_rdata));

  tsfvl_ram #(.WIDTH(48), .DEPTH(2*RECORDS)) u_rec (
    .clk_i, .we_i(rc_we), .waddr_i(rc_waddr), .wdata_i(rc_wdata),
    .re_i(rc_re), .raddr_i(rc_raddr), .rdata_o(rc_rraw));

  assign rc_rdata   = log_rec_t'(rc_rraw);
  assign sv_val     = sv_rv_q ? sv_rdata : 32'd0;
  assign cnt        = (rps_q > CNT_W'(RECORDS)) ? CNT_W'(RECORDS) : rps_q;
  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign emit_ok    = !ov_q || out_ready_i;
  // replay check: id matches inverted check byte and indexes a value
  assign rec_good   = (rc_rdata.id == ~rc_rdata.idn) &&
                      ({24'd0, rc_rdata.id} < VALUE_COUNT);
  assign rec_empty  = (rc_rdata.id == 8'hFF) && (rc_rdata.idn == 8'hFF) &&
                      (rc_rdata.val == 32'hFFFF_FFFF);
  assign v0 = (hdr_sig_q[0] == sig_word_q);
  assign v1 = (hdr_sig_q[1] == sig_word_q);

  always_comb begin
    state_d = state_q; idx_d = idx_q; didx_d = didx_q; pend_d = 1'b0;
    sec_d = sec_q; hsec_d = hsec_q; two_d = two_q; act_d = act_q; st_d = st_q;
    serial_d = serial_q; id_d = id_q; word_d = word_q;
    emit = 1'b0; e_kind = K_STATUS; e_sec = 1'b0; e_slot = '0; e_id = '0;
    e_word = '0; e_st = 1'b0; e_last = 1'b0;
    sv_we = 1'b0; sv_re = 1'b0; sv_waddr = id_q; sv_raddr = id_q; sv_wdata = word_q;
    sn_we = 1'b0; sn_re = 1'b0; sn_waddr = {sec_q, idx_q[VAL_AW-1:0]};
    sn_raddr = {sec_q, idx_q[VAL_AW-1:0]}; sn_wdata = 32'hFFFF_FFFF;
    rc_we = 1'b0; rc_re = 1'b0; rc_waddr = {sec_q, idx_q[REC_AW-1:0]};
    rc_raddr = {sec_q, idx_q[REC_AW-1:0]};
    rc_wdata = '{id: 8'hFF, idn: 8'hFF, val: 32'hFFFF_FFFF};
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          unique case (opcode_e'(opcode_i))
            OP_LOAD_SIG, OP_LOAD_SER, OP_NONE: ;
            OP_LOAD_SNAP: begin
              sn_we    = ({23'd0, in_slot_i} < VALUE_COUNT);
              sn_waddr = {in_sector_i, in_slot_i[VAL_AW-1:0]};
              sn_wdata = in_word_i;
            end
            OP_LOAD_REC: begin
              rc_we    = 1'b1;
              rc_waddr = {in_sector_i, in_slot_i[REC_AW-1:0]};
              rc_wdata = '{id: in_id_i, idn: in_id_check_i, val: in_word_i};
            end
            OP_MOUNT: begin
              st_d = 1'b0; idx_d = '0;
              if (!v0 && !v1) begin
                sec_d = 1'b0; two_d = 1'b1; hsec_d = 1'b0; serial_d = 32'd1;
                act_d = 1'b0; state_d = S_ERASE;
              end else begin
                sec_d = v1 && (!v0 || hdr_ser_q[0] < hdr_ser_q[1]);
                act_d = sec_d; state_d = S_COPY;
              end
            end
            OP_SAVE: begin
              id_d = in_id_i[VAL_AW-1:0]; word_d = in_word_i;
              if (!unlock_q) begin
                st_d = 1'b1; state_d = S_STATUS;
              end else begin
                st_d = 1'b0; sec_d = act_q; sv_re = 1'b1;
                sv_raddr = in_id_i[VAL_AW-1:0]; state_d = S_SVCMP;
              end
            end
            OP_READ: begin
              id_d = in_id_i[VAL_AW-1:0]; sv_re = 1'b1;
              sv_raddr = in_id_i[VAL_AW-1:0]; state_d = S_RDOUT;
            end
            default: ;
          endcase
        end
      end
      S_ERASE: begin
        rc_we = 1'b1;
        sn_we = (idx_q < CNT_W'(VALUE_COUNT));
        if (idx_q != CNT_W'(RECORDS - 1)) begin
          idx_d = idx_q + 1'b1;
        end else if (emit_ok) begin
          emit = 1'b1; e_kind = K_ERASE; e_sec = sec_q; idx_d = '0;
          if (two_q) begin
            two_d = 1'b0; sec_d = 1'b1;
          end else begin
            state_d = S_HDR;
          end
        end
      end
      S_HDR: begin
        if (emit_ok) begin
          emit = 1'b1; e_kind = K_HEADER; e_sec = hsec_q; e_word = serial_q;
          idx_d = '0; state_d = S_SRD;
        end
      end
      S_SRD: begin
        sv_re = 1'b1; sv_raddr = idx_q[VAL_AW-1:0]; state_d = S_SWR;
      end
      S_SWR: begin
        if (emit_ok) begin
          emit = 1'b1; e_kind = K_SNAP; e_sec = hsec_q; e_slot = 9'(idx_q);
          e_word = sv_val;
          sn_we = 1'b1; sn_waddr = {hsec_q, idx_q[VAL_AW-1:0]}; sn_wdata = sv_val;
          if (idx_q == CNT_W'(VALUE_COUNT - 1)) begin
            state_d = S_STATUS;
          end else begin
            idx_d = idx_q + 1'b1; state_d = S_SRD;
          end
        end
      end
      S_COPY: begin
        if (pend_q) begin
          sv_we = 1'b1; sv_waddr = didx_q[VAL_AW-1:0]; sv_wdata = sn_rdata;
        end
        if (idx_q < CNT_W'(VALUE_COUNT)) begin
          sn_re = 1'b1; didx_d = idx_q; idx_d = idx_q + 1'b1; pend_d = 1'b1;
        end else begin
          idx_d = '0; state_d = S_REPLAY;
        end
      end
      S_REPLAY: begin
        if (pend_q && !rec_good) begin
          state_d = S_STATUS;
        end else begin
          if (pend_q) begin
            sv_we = 1'b1; sv_waddr = rc_rdata.id[VAL_AW-1:0]; sv_wdata = rc_rdata.val;
          end
          if (idx_q < cnt) begin
            rc_re = 1'b1; didx_d = idx_q; idx_d = idx_q + 1'b1; pend_d = 1'b1;
          end else begin
            state_d = S_STATUS;
          end
        end
      end
      S_SVCMP: begin
        if (sv_val == word_q) begin
          state_d = S_STATUS;
        end else begin
          sv_we = 1'b1; idx_d = '0; state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (pend_q && rec_empty) begin
          state_d = S_FOUND;
        end else if (idx_q < cnt) begin
          rc_re = 1'b1; didx_d = idx_q; idx_d = idx_q + 1'b1; pend_d = 1'b1;
        end else begin
          // sector full: move to the other one with a fresh snapshot
          serial_d = hdr_ser_q[sec_q] + 32'd1;
          sec_d = ~sec_q; hsec_d = ~sec_q; act_d = ~sec_q; two_d = 1'b0;
          idx_d = '0; state_d = S_ERASE;
        end
      end
      S_FOUND: begin
        if (emit_ok) begin
          emit = 1'b1; e_kind = K_RECORD; e_sec = sec_q; e_slot = 9'(didx_q);
          e_id = 5'(id_q); e_word = word_q;
          rc_we = 1'b1; rc_waddr = {sec_q, didx_q[REC_AW-1:0]};
          rc_wdata = '{id: 8'(id_q), idn: ~8'(id_q), val: word_q};
          state_d = S_STATUS;
        end
      end
      S_RDOUT: begin
        if (emit_ok) begin
          emit = 1'b1; e_kind = K_READ; e_sec = act_q; e_id = 5'(id_q);
          e_word = sv_val; e_last = 1'b1; state_d = S_IDLE;
        end
      end
      S_STATUS: begin
        if (emit_ok) begin
          emit = 1'b1; e_kind = K_STATUS; e_sec = act_q; e_st = st_q;
          e_last = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; idx_q <= '0; didx_q <= '0; pend_q <= 1'b0;
      sec_q <= 1'b0; hsec_q <= 1'b0; two_q <= 1'b0; act_q <= 1'b0; st_q <= 1'b0;
      serial_q <= '0; id_q <= '0; word_q <= '0;
      unlock_q <= 1'b0; sig_word_q <= '0; rps_q <= CNT_W'(495);
      sv_vld_q <= '0; sv_rv_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; idx_q <= idx_d; didx_q <= didx_d; pend_q <= pend_d;
      sec_q <= sec_d; hsec_q <= hsec_d; two_q <= two_d; act_q <= act_d; st_q <= st_d;
      serial_q <= serial_d; id_q <= id_d; word_q <= word_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_UNLOCK: unlock_q   <= cfg_data_i[0];
          CFG_SIG:    sig_word_q <= cfg_data_i;
          CFG_RPS:    rps_q      <= cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (sv_we) sv_vld_q[sv_waddr] <= 1'b1;
      if (sv_re) sv_rv_q <= sv_vld_q[sv_raddr];
      if (emit) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  // header mirror and output payload
  always_ff @(posedge clk_i) begin
    if (acc && opcode_e'(opcode_i) == OP_LOAD_SIG) hdr_sig_q[in_sector_i] <= in_word_i;
    if (acc && opcode_e'(opcode_i) == OP_LOAD_SER) hdr_ser_q[in_sector_i] <= in_word_i;
    if (state_q == S_ERASE && idx_q == CNT_W'(RECORDS - 1)) begin
      hdr_sig_q[sec_q] <= 32'hFFFF_FFFF;
      hdr_ser_q[sec_q] <= 32'hFFFF_FFFF;
    end
    if (state_q == S_HDR && emit_ok) begin
      hdr_sig_q[hsec_q] <= sig_word_q;
      hdr_ser_q[hsec_q] <= serial_q;
    end
    if (emit) begin
      ok_q <= e_kind; osec_q <= e_sec; oslot_q <= e_slot; oid_q <= e_id;
      oword_q <= e_word; ost_q <= e_st; olast_q <= e_last;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_kind_o   = ok_q;
  assign out_sector_o = osec_q;
  assign out_slot_o   = oslot_q;
  assign out_id_o     = oid_q;
  assign out_word_o   = oword_q;
  assign status_o     = ost_q;
  assign last_o       = olast_q;

  // a result is never pushed over one still waiting
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(emit && ov_q && !out_ready_i)) else $error("result overrun");
  // scans never run past the slot count
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REPLAY || state_q == S_SEARCH) |-> idx_q <= cnt)
    else $error("scan index past slot count");
  // no read in flight once back in idle
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_q) else $error("stale read in idle");
endmodule

@@ rtl/tsfvl_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tsfvl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ tb/two_sector_flash_value_log_core_tb.sv @@
// Testbench for two_sector_flash_value_log_core: directed and random transactions,
// checked against an in-bench predictor of the value log. Depends on tsfvl_pkg.
`timescale 1ns / 1ps

module two_sector_flash_value_log_core_tb;
  import tsfvl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  // Quiet gap after the last result before the next step.
  localparam int unsigned SETTLE_CYCLES = 800;

  typedef struct {
    kind_e       kind;
    logic        sector;
    logic [8:0]  slot;
    logic [4:0]  id;
    logic [31:0] word;
    logic        status;
    logic        last;
  } flash_op_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  opcode_i;
  logic        in_sector_i;
  logic [8:0]  in_slot_i;
  logic [7:0]  in_id_i;
  logic [7:0]  in_id_check_i;
  logic [31:0] in_word_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  out_kind_o;
  logic        out_sector_o;
  logic [8:0]  out_slot_o;
  logic [4:0]  out_id_o;
  logic [31:0] out_word_o;
  logic        status_o;
  logic        last_o;

  two_sector_flash_value_log_core dut (.*);

  // Clock: 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: values, both sector mirrors and configuration.
  // ---------------------------------------------------------------------------
  logic [31:0] sh_values [VALUE_COUNT];
  logic [7:0]  sh_rec_id [2*RECORDS];
  logic [7:0]  sh_rec_idn[2*RECORDS];
  logic [31:0] sh_rec_val[2*RECORDS];
  logic [31:0] sh_serial [2];
  logic [31:0] sh_sig    [2];
  logic [31:0] sh_snap   [2*VALUE_COUNT];
  logic        sh_active;
  logic        cfg_unlocked;
  logic [31:0] cfg_sig;
  logic [9:0]  cfg_rps;

  flash_op_t   expected_ops[$];
  flash_op_t   pending_ops[$];   // results of the transaction being predicted
  int unsigned error_count;
  int unsigned cycle_count;

  // Idle percentages and a long receiver hold-off counter.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned recv_hold;

  function automatic int unsigned slots_in_use();
    return (cfg_rps > RECORDS) ? RECORDS : cfg_rps;
  endfunction

  function automatic void push_op(kind_e k, logic s, logic [8:0] sl, logic [4:0] id,
                                  logic [31:0] w, logic st);
    flash_op_t op;
    op.kind = k; op.sector = s; op.slot = sl; op.id = id;
    op.word = w; op.status = st; op.last = 1'b0;
    pending_ops.push_back(op);
  endfunction

  function automatic void erase_shadow(logic s);
    for (int i = 0; i < RECORDS; i++) begin
      sh_rec_id[s*RECORDS+i]  = 8'hFF;
      sh_rec_idn[s*RECORDS+i] = 8'hFF;
      sh_rec_val[s*RECORDS+i] = 32'hFFFF_FFFF;
    end
    sh_sig[s]    = 32'hFFFF_FFFF;
    sh_serial[s] = 32'hFFFF_FFFF;
    for (int i = 0; i < VALUE_COUNT; i++) sh_snap[s*VALUE_COUNT+i] = 32'hFFFF_FFFF;
    push_op(K_ERASE, s, '0, '0, '0, 1'b0);
  endfunction

  function automatic void header_shadow(logic s, logic [31:0] serial);
    sh_sig[s]    = cfg_sig;
    sh_serial[s] = serial;
    push_op(K_HEADER, s, '0, '0, serial, 1'b0);
    for (int i = 0; i < VALUE_COUNT; i++) begin
      sh_snap[s*VALUE_COUNT+i] = sh_values[i];
      push_op(K_SNAP, s, 9'(i), '0, sh_values[i], 1'b0);
    end
  endfunction

  function automatic void mount_shadow();
    logic v0, v1, sel;
    int unsigned base;
    v0 = (sh_sig[0] == cfg_sig);
    v1 = (sh_sig[1] == cfg_sig);
    if (!v0 && !v1) begin
      // Neither sector valid: format both, fresh header in sector 0.
      erase_shadow(1'b0);
      erase_shadow(1'b1);
      header_shadow(1'b0, 32'd1);
      sh_active = 1'b0;
      return;
    end
    sel = 1'b0;
    if (v1 && (!v0 || sh_serial[0] < sh_serial[1])) sel = 1'b1;
    sh_active = sel;
    for (int i = 0; i < VALUE_COUNT; i++) sh_values[i] = sh_snap[sel*VALUE_COUNT+i];
    for (int i = 0; i < slots_in_use(); i++) begin
      base = sel*RECORDS + i;
      // Replay stops at the first record with a bad check or out-of-range id.
      if (sh_rec_id[base] == (sh_rec_idn[base] ^ 8'hFF) && sh_rec_id[base] < VALUE_COUNT)
        sh_values[sh_rec_id[base][4:0]] = sh_rec_val[base];
      else
        break;
    end
  endfunction

  function automatic logic save_shadow(logic [7:0] id_in, logic [31:0] w);
    logic [4:0]  id;
    logic        s;
    logic [31:0] serial;
    int unsigned base;
    if (!cfg_unlocked) return 1'b1;
    id = id_in[4:0];
    if (sh_values[id] == w) return 1'b0;
    sh_values[id] = w;
    s = sh_active;
    for (int i = 0; i < slots_in_use(); i++) begin
      base = s*RECORDS + i;
      if (sh_rec_id[base] == 8'hFF && sh_rec_idn[base] == 8'hFF &&
          sh_rec_val[base] == 32'hFFFF_FFFF) begin
        sh_rec_id[base]  = {3'b000, id};
        sh_rec_idn[base] = {3'b000, id} ^ 8'hFF;
        sh_rec_val[base] = w;
        push_op(K_RECORD, s, 9'(i), id, w, 1'b0);
        return 1'b0;
      end
    end
    // Sector full: move to the other sector with a new snapshot.
    serial = sh_serial[s] + 32'd1;
    s = ~s;
    sh_active = s;
    erase_shadow(s);
    header_shadow(s, serial);
    return 1'b0;
  endfunction

  // Predict the results of one accepted transaction and queue them.
  function automatic void predict_log_op(logic [2:0] op, logic sec, logic [8:0] slot,
                                         logic [7:0] id, logic [7:0] idc, logic [31:0] w);
    logic st;
    pending_ops.delete();
    case (opcode_e'(op))
      OP_LOAD_SIG:  sh_sig[sec] = w;
      OP_LOAD_SER:  sh_serial[sec] = w;
      OP_LOAD_SNAP: if (slot < VALUE_COUNT) sh_snap[sec*VALUE_COUNT+slot] = w;
      OP_LOAD_REC: begin
        sh_rec_id[sec*RECORDS+slot]  = id;
        sh_rec_idn[sec*RECORDS+slot] = idc;
        sh_rec_val[sec*RECORDS+slot] = w;
      end
      OP_MOUNT: begin
        mount_shadow();
        push_op(K_STATUS, sh_active, '0, '0, '0, 1'b0);
      end
      OP_SAVE: begin
        st = save_shadow(id, w);
        push_op(K_STATUS, sh_active, '0, '0, '0, st);
      end
      OP_READ: push_op(K_READ, sh_active, '0, id[4:0], sh_values[id[4:0]], 1'b0);
      default: ;
    endcase
    if (pending_ops.size() > 0) begin
      pending_ops[pending_ops.size()-1].last = 1'b1;
      foreach (pending_ops[i]) expected_ops.push_back(pending_ops[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver side
  // ---------------------------------------------------------------------------
  // Sends one transaction; called at a rising edge, returns at the edge of
  // acceptance with valid still high so back-to-back items need no toggle.
  task automatic send_op(logic [2:0] op, logic sec, logic [8:0] slot, logic [7:0] id,
                         logic [7:0] idc, logic [31:0] w);
    int unsigned gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    opcode_i      <= op;
    in_sector_i   <= sec;
    in_slot_i     <= slot;
    in_id_i       <= id;
    in_id_check_i <= idc;
    in_word_i     <= w;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_log_op(op, sec, slot, id, idc, w);
  endtask

  // Lowers valid and waits until the block has drained and settled.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_ops.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_UNLOCK: cfg_unlocked = data[0];
      CFG_SIG:    cfg_sig = data;
      CFG_RPS:    cfg_rps = data[9:0];
      default: ;
    endcase
  endtask

  task automatic save_op(logic [7:0] id, logic [31:0] w);
    send_op(OP_SAVE, 1'($urandom_range(0, 1)), 9'($urandom), id, 8'($urandom), w);
  endtask

  task automatic read_op(logic [7:0] id);
    send_op(OP_READ, 1'($urandom_range(0, 1)), 9'($urandom), id, 8'($urandom), $urandom);
  endtask

  task automatic mount_op();
    send_op(OP_MOUNT, 1'($urandom_range(0, 1)), 9'($urandom), 8'($urandom),
            8'($urandom), $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (recv_hold != 0) begin
      recv_hold   <= recv_hold - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    flash_op_t exp_op;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_ops.size() == 0) begin
        $display("%0t: unexpected result kind=%0d sec=%0d slot=%0d id=%0d word=%h st=%0d last=%0d",
                 $time, out_kind_o, out_sector_o, out_slot_o, out_id_o, out_word_o,
                 status_o, last_o);
        error_count++;
      end else begin
        exp_op = expected_ops.pop_front();
        if (out_kind_o !== exp_op.kind || out_sector_o !== exp_op.sector ||
            out_slot_o !== exp_op.slot || out_id_o !== exp_op.id ||
            out_word_o !== exp_op.word || status_o !== exp_op.status ||
            last_o !== exp_op.last) begin
          $display("%0t: mismatch expected kind=%0d sec=%0d slot=%0d id=%0d word=%h st=%0d last=%0d",
                   $time, exp_op.kind, exp_op.sector, exp_op.slot, exp_op.id, exp_op.word,
                   exp_op.status, exp_op.last);
          $display("%0t:          actual   kind=%0d sec=%0d slot=%0d id=%0d word=%h st=%0d last=%0d",
                   $time, out_kind_o, out_sector_o, out_slot_o, out_id_o, out_word_o,
                   status_o, last_o);
          error_count++;
        end
      end
    end
  end

  // Run-length guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reads before any mount: values are zero out of reset; index above 31 wraps.
  task automatic test_reset_reads();
    read_op(8'd0);
    read_op(8'd31);
    read_op(8'hFF);
    wait_idle();
  endtask

  // Mount with no valid sector formats both; save while locked is refused.
  task automatic test_format_and_lock();
    write_reg(CFG_SIG, 32'hA5C3_0001);
    send_op(OP_LOAD_SIG, 1'b0, '0, '0, '0, 32'h0000_0000);
    send_op(OP_LOAD_SIG, 1'b1, '0, '0, '0, 32'hFFFF_FFFF);
    mount_op();
    save_op(8'd4, 32'h1234_5678);
    read_op(8'd4);
    wait_idle();
  endtask

  // Record append, unchanged save, sector move and serial wrap.
  task automatic test_save_and_wrap();
    write_reg(CFG_UNLOCK, 32'd1);
    write_reg(CFG_RPS, 32'd2);
    send_op(OP_LOAD_SER, 1'b0, '0, '0, '0, 32'hFFFF_FFFF);
    save_op(8'd5, 32'hDEAD_BEEF);
    save_op(8'd5, 32'hDEAD_BEEF);          // unchanged value: status only
    save_op(8'hE7, 32'h0000_0007);         // id masked to 7
    save_op(8'd31, 32'hFFFF_FFFF);         // sector full: move, serial wraps to 0
    mount_op();                            // sector 0 keeps the higher serial
    send_op(OP_LOAD_SER, 1'b1, '0, '0, '0, 32'hFFFF_FFFF);
    mount_op();                            // equal serials: sector 0 wins
    read_op(8'd5);
    wait_idle();
  endtask

  // Replay of loaded records: good ones applied, stop at bad check and bad id.
  task automatic test_replay();
    write_reg(CFG_RPS, 32'd1023);          // clipped to the record store size
    send_op(OP_LOAD_SIG, 1'b1, '0, '0, '0, 32'hA5C3_0001);
    send_op(OP_LOAD_SER, 1'b1, '0, '0, '0, 32'h7FFF_FFFF);
    send_op(OP_LOAD_SER, 1'b0, '0, '0, '0, 32'h0000_0010);
    send_op(OP_LOAD_SNAP, 1'b1, 9'd3, '0, '0, 32'h3333_3333);
    send_op(OP_LOAD_SNAP, 1'b1, 9'd40, '0, '0, 32'h4444_4444);   // ignored index
    send_op(OP_LOAD_REC, 1'b1, 9'd0, 8'd3, 8'hFC, 32'hAAAA_0003);
    send_op(OP_LOAD_REC, 1'b1, 9'd1, 8'd9, 8'hF6, 32'hAAAA_0009);
    send_op(OP_LOAD_REC, 1'b1, 9'd2, 8'd40, 8'hD7, 32'hBBBB_0000); // id out of range
    send_op(OP_LOAD_REC, 1'b1, 9'd3, 8'd1, 8'hFE, 32'hCCCC_0001);
    send_op(OP_NONE, 1'b1, 9'h1FF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    mount_op();
    read_op(8'd3);
    read_op(8'd9);
    read_op(8'd1);
    send_op(OP_LOAD_REC, 1'b1, 9'd2, 8'd2, 8'h00, 32'h0);        // bad check
    mount_op();
    wait_idle();
    write_reg(CFG_RPS, 32'd0);             // every changing save moves
    save_op(8'd2, 32'h0000_0002);
    wait_idle();
    write_reg(CFG_UNLOCK, 32'd0);
    save_op(8'd2, 32'h0000_0003);
    wait_idle();
  endtask

  // Random mix, mostly saves, reads and mounts, with loads and noise.
  task automatic random_ops(int unsigned count);
    int unsigned r;
    logic [7:0]  id;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
      if (r < 38) begin
        save_op(id, ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 3)) : $urandom);
      end else if (r < 58) begin
        read_op(id);
      end else if (r < 66) begin
        mount_op();
      end else if (r < 80) begin
        send_op(OP_LOAD_REC, 1'($urandom_range(0, 1)),
                ($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(0, 7)),
                id, ($urandom_range(0, 5) == 0) ? 8'($urandom) : ~id, $urandom);
      end else if (r < 86) begin
        send_op(OP_LOAD_SNAP, 1'($urandom_range(0, 1)),
                ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 31)),
                8'($urandom), 8'($urandom), $urandom);
      end else if (r < 90) begin
        send_op(OP_LOAD_SER, 1'($urandom_range(0, 1)), 9'($urandom), 8'($urandom),
                8'($urandom), ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom);
      end else if (r < 94) begin
        send_op(OP_LOAD_SIG, 1'($urandom_range(0, 1)), 9'($urandom), 8'($urandom),
                8'($urandom), ($urandom_range(0, 1) == 0) ? cfg_sig : $urandom);
      end else begin
        send_op(($urandom_range(0, 1) == 0) ? OP_NONE : 3'($urandom_range(0, 6)),
                1'($urandom_range(0, 1)), 9'($urandom), 8'($urandom), 8'($urandom),
                $urandom);
      end
    end
  endtask

  task automatic test_random_phase(int unsigned s_pct, int unsigned r_pct,
                                   logic [9:0] rps, int unsigned count);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    write_reg(CFG_RPS, 32'(rps));
    write_reg(CFG_UNLOCK, 32'($urandom_range(0, 5) != 0));
    if ($urandom_range(0, 2) == 0) write_reg(CFG_SIG, $urandom);
    mount_op();
    random_ops(count);
    wait_idle();
  endtask

  // Receiver stalls for a long stretch while transactions keep coming.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_UNLOCK, 32'd1);
    write_reg(CFG_RPS, 32'd3);
    recv_hold = 600;
    for (int n = 0; n < 24; n++) begin
      if (n % 3 == 0) save_op(8'($urandom_range(0, 31)), $urandom);
      else read_op(8'($urandom));
    end
    wait_idle();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    opcode_i      <= '0;
    in_sector_i   <= 1'b0;
    in_slot_i     <= '0;
    in_id_i       <= '0;
    in_id_check_i <= '0;
    in_word_i     <= '0;
    error_count   = 0;
    cycle_count   = 0;
    recv_hold     = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_unlocked  = 1'b0;
    cfg_sig       = '0;
    cfg_rps       = 10'd495;
    sh_active     = 1'b0;
    foreach (sh_values[i]) sh_values[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_reads();
    test_format_and_lock();   // mirror fully defined from here on
    test_save_and_wrap();
    test_replay();
    test_random_phase(38, 59, 10'd4, 75);
    test_random_phase(38, 59, 10'd512, 75);
    test_random_phase(59, 38, 10'd1, 75);
    test_random_phase(59, 38, 10'd0, 40);
    test_random_phase(0, 0, 10'($urandom_range(2, 12)), 75);
    test_random_phase(0, 0, 10'd1023, 40);
    test_backpressure();

    if (error_count == 0 && expected_ops.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ two_sector_flash_value_log_core.f @@
rtl/tsfvl_pkg.sv
rtl/tsfvl_ram.sv
rtl/two_sector_flash_value_log_core.sv
tb/two_sector_flash_value_log_core_tb.sv
